[rtl/core/hcma_pkg.sv]
package hcma_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int NUM_STATS   = 21;

  // Transaction modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DUMP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Statistic indexes
  localparam logic [4:0] STAT_COUNT      = 5'd0;
  localparam logic [4:0] STAT_WSUM       = 5'd1;
  localparam logic [4:0] STAT_W2SUM      = 5'd2;
  localparam logic [4:0] STAT_XMASS      = 5'd3;
  localparam logic [4:0] STAT_YMASS      = 5'd4;
  localparam logic [4:0] STAT_TMASS      = 5'd5;
  localparam logic [4:0] STAT_XMASS2     = 5'd6;
  localparam logic [4:0] STAT_YMASS2     = 5'd7;
  localparam logic [4:0] STAT_TMASS2     = 5'd8;
  localparam logic [4:0] STAT_TMIN       = 5'd9;
  localparam logic [4:0] STAT_TMAX       = 5'd10;
  localparam logic [4:0] STAT_XMIN       = 5'd11;
  localparam logic [4:0] STAT_XMAX       = 5'd12;
  localparam logic [4:0] STAT_YMIN       = 5'd13;
  localparam logic [4:0] STAT_YMAX       = 5'd14;
  localparam logic [4:0] STAT_XEARLY     = 5'd15;
  localparam logic [4:0] STAT_YEARLY     = 5'd16;
  localparam logic [4:0] STAT_XLATE      = 5'd17;
  localparam logic [4:0] STAT_YLATE      = 5'd18;
  localparam logic [4:0] STAT_LATE_FIRST = 5'd19;
  localparam logic [4:0] STAT_LATE_LAST  = 5'd20;

  // Multiplier operations, issued in this order for each hit
  typedef enum logic [3:0] {
    OP_W2   = 4'd0,
    OP_WX   = 4'd1,
    OP_WY   = 4'd2,
    OP_WTL  = 4'd3,
    OP_WTH  = 4'd4,
    OP_W2X  = 4'd5,
    OP_W2Y  = 4'd6,
    OP_W2TL = 4'd7,
    OP_W2TH = 4'd8
  } mul_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       mul_en;
    mul_op_t    mul_op;
    logic       out_load;
    logic [4:0] stat_idx;
  } hcma_cmd_t;

endpackage

[rtl/core/hit_cluster_moment_accumulator_unit.sv]
// Hit cluster moment accumulator.
// Input channel (in_valid / in_stall): one transaction per command. in_mode
// selects insert hit, dump statistics then clear, or clear only; mode 3 is
// dropped. in_stall is high while a command is still being worked on.
// Insert: accepted, then nine product steps through the one
// shared 32x32 multiplier and one final accumulate, all before the next
// command is taken. A clear is applied as the command is accepted.
// Dump: 21 result transactions (stat_index 0..20, last_of_run on index 20),
// the first valid once the dump state has loaded the output register,
// then one per cycle when the receiver does not stall; the cluster is
// cleared as the last statistic is loaded and the next command is accepted
// right after, while that statistic still waits in the output register.
// Output channel (out_valid / out_stall): a single output register; while a
// result is pending and out_stall is high, the payload and dump sequence hold.
// Reset (rst_n low, synchronous): all statistics zero, no result pending.
module hit_cluster_moment_accumulator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_hit_time,
  input  logic [15:0] in_hit_x,
  input  logic [15:0] in_hit_y,
  input  logic [15:0] in_hit_weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_stat_index,
  output logic [63:0] out_stat_value,
  output logic        out_last_of_run
);
  import hcma_pkg::*;

  hcma_cmd_t cmd;

  hcma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hcma_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_hit_time     (in_hit_time),
    .in_hit_x        (in_hit_x),
    .in_hit_y        (in_hit_y),
    .in_hit_weight   (in_hit_weight),
    .out_stat_index  (out_stat_index),
    .out_stat_value  (out_stat_value),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  // never overwrite a result the receiver has not taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // the run marker sits on the final statistic only
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> (out_stat_index == STAT_LATE_LAST))
    else $error("last_of_run on wrong statistic");

  // multiplier steps run only while input is held off
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> in_stall)
    else $error("multiplier step while input open");

  // a hit capture is followed by the first product step
  a_capture_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (cmd.mul_en && (cmd.mul_op == OP_W2)))
    else $error("capture not followed by product sequence");
`endif

endmodule

[rtl/core/hcma_ctrl.sv]
module hcma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  output logic                out_valid,
  input  logic                out_stall,
  output hcma_pkg::hcma_cmd_t cmd
);
  import hcma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_DUMP
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Sequence commands and next state
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.mul_op   = mul_op_t'(step_r);
    cmd.stat_idx = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_INSERT: begin
              cmd.capture = 1'b1;
              step_nxt    = 4'd0;
              state_nxt   = ST_MUL;
            end
            MODE_DUMP: begin
              idx_nxt   = STAT_COUNT;
              state_nxt = ST_DUMP;
            end
            MODE_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (mul_op_t'(step_r) == OP_W2TH) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_DUMP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          if (idx_r == STAT_LATE_LAST) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold output valid until the receiver takes the transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      idx_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/hcma_datapath.sv]
module hcma_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  hcma_pkg::hcma_cmd_t cmd,
  input  logic [63:0]         in_hit_time,
  input  logic [15:0]         in_hit_x,
  input  logic [15:0]         in_hit_y,
  input  logic [15:0]         in_hit_weight,
  output logic [4:0]          out_stat_index,
  output logic [63:0]         out_stat_value,
  output logic                out_last_of_run
);
  import hcma_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Captured hit
  logic [63:0] t_r;
  logic [15:0] x_r, y_r, w_r;
  logic [31:0] w2_r;

  // Multiplier stage
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  mul_op_t     prod_op_r;
  logic        prod_vld_r;

  // Cluster statistics
  logic [COUNT_WIDTH-1:0] hit_count_r;
  logic [63:0] wsum_r, w2sum_r, xm_r, ym_r, tm_r, xm2_r, ym2_r, tm2_r;
  logic [63:0] tmin_r, tmax_r;
  logic [15:0] xmin_r, xmax_r, ymin_r, ymax_r;
  logic [15:0] xe_r, ye_r, xl_r, yl_r;
  logic [COUNT_WIDTH-1:0] lfirst_r, llast_r;

  logic [63:0] stat_val;
  logic [4:0]  stat_idx_r;
  logic [63:0] stat_val_r;
  logic        stat_last_r;

  // Select multiplier operands
  always_comb begin
    mul_a = {16'b0, w_r};
    mul_b = {16'b0, w_r};
    case (cmd.mul_op)
      OP_W2:   mul_b = {16'b0, w_r};
      OP_WX:   mul_b = {16'b0, x_r};
      OP_WY:   mul_b = {16'b0, y_r};
      OP_WTL:  mul_b = t_r[31:0];
      OP_WTH:  mul_b = t_r[63:32];
      OP_W2X: begin
        mul_a = w2_r;
        mul_b = {16'b0, x_r};
      end
      OP_W2Y: begin
        mul_a = w2_r;
        mul_b = {16'b0, y_r};
      end
      OP_W2TL: begin
        mul_a = w2_r;
        mul_b = t_r[31:0];
      end
      OP_W2TH: begin
        mul_a = w2_r;
        mul_b = t_r[63:32];
      end
      default: ;
    endcase
  end

  // Register the hit and the product
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r <= in_hit_time;
      x_r <= in_hit_x;
      y_r <= in_hit_y;
      w_r <= in_hit_weight;
    end
    if (cmd.mul_en) begin
      prod_r    <= {32'b0, mul_a} * {32'b0, mul_b};
      prod_op_r <= cmd.mul_op;
    end
    if (prod_vld_r && (prod_op_r == OP_W2)) begin
      w2_r <= prod_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  // Clear or update counts, sums and bounds
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      hit_count_r <= '0;
      wsum_r <= '0; w2sum_r <= '0; xm_r <= '0; ym_r <= '0; tm_r <= '0;
      xm2_r <= '0; ym2_r <= '0; tm2_r <= '0;
      tmin_r <= '0; tmax_r <= '0;
      xmin_r <= '0; xmax_r <= '0; ymin_r <= '0; ymax_r <= '0;
      xe_r <= '0; ye_r <= '0; xl_r <= '0; yl_r <= '0;
      lfirst_r <= '0; llast_r <= '0;
    end else begin
      if (cmd.capture) begin
        wsum_r <= wsum_r + {48'b0, in_hit_weight};
        if (hit_count_r != COUNT_MAX) begin
          hit_count_r <= hit_count_r + COUNT_WIDTH'(1);
        end
        if (hit_count_r == '0) begin
          // first hit seeds every bound
          tmin_r <= in_hit_time; tmax_r <= in_hit_time;
          xmin_r <= in_hit_x; xmax_r <= in_hit_x;
          ymin_r <= in_hit_y; ymax_r <= in_hit_y;
          xe_r <= in_hit_x; ye_r <= in_hit_y;
          xl_r <= in_hit_x; yl_r <= in_hit_y;
          lfirst_r <= '0; llast_r <= '0;
        end else begin
          if (in_hit_time < tmin_r) begin
            tmin_r <= in_hit_time;
            xe_r   <= in_hit_x;
            ye_r   <= in_hit_y;
          end
          // a tie at the latest time moves only the last index
          if (in_hit_time == tmax_r) begin
            llast_r <= hit_count_r;
          end else if (in_hit_time > tmax_r) begin
            lfirst_r <= hit_count_r;
            llast_r  <= hit_count_r;
            tmax_r   <= in_hit_time;
            xl_r     <= in_hit_x;
            yl_r     <= in_hit_y;
          end
          if (in_hit_x < xmin_r) xmin_r <= in_hit_x;
          if (in_hit_x > xmax_r) xmax_r <= in_hit_x;
          if (in_hit_y < ymin_r) ymin_r <= in_hit_y;
          if (in_hit_y > ymax_r) ymax_r <= in_hit_y;
        end
      end
      // accumulate the registered product
      if (prod_vld_r) begin
        case (prod_op_r)
          OP_W2:   w2sum_r <= w2sum_r + prod_r;
          OP_WX:   xm_r    <= xm_r + prod_r;
          OP_WY:   ym_r    <= ym_r + prod_r;
          OP_WTL:  tm_r    <= tm_r + prod_r;
          OP_WTH:  tm_r    <= tm_r + {prod_r[31:0], 32'b0};
          OP_W2X:  xm2_r   <= xm2_r + prod_r;
          OP_W2Y:  ym2_r   <= ym2_r + prod_r;
          OP_W2TL: tm2_r   <= tm2_r + prod_r;
          OP_W2TH: tm2_r   <= tm2_r + {prod_r[31:0], 32'b0};
          default: ;
        endcase
      end
    end
  end

  // Select the statistic to emit
  always_comb begin
    case (cmd.stat_idx)
      STAT_COUNT:      stat_val = 64'(hit_count_r);
      STAT_WSUM:       stat_val = wsum_r;
      STAT_W2SUM:      stat_val = w2sum_r;
      STAT_XMASS:      stat_val = xm_r;
      STAT_YMASS:      stat_val = ym_r;
      STAT_TMASS:      stat_val = tm_r;
      STAT_XMASS2:     stat_val = xm2_r;
      STAT_YMASS2:     stat_val = ym2_r;
      STAT_TMASS2:     stat_val = tm2_r;
      STAT_TMIN:       stat_val = tmin_r;
      STAT_TMAX:       stat_val = tmax_r;
      STAT_XMIN:       stat_val = {48'b0, xmin_r};
      STAT_XMAX:       stat_val = {48'b0, xmax_r};
      STAT_YMIN:       stat_val = {48'b0, ymin_r};
      STAT_YMAX:       stat_val = {48'b0, ymax_r};
      STAT_XEARLY:     stat_val = {48'b0, xe_r};
      STAT_YEARLY:     stat_val = {48'b0, ye_r};
      STAT_XLATE:      stat_val = {48'b0, xl_r};
      STAT_YLATE:      stat_val = {48'b0, yl_r};
      STAT_LATE_FIRST: stat_val = 64'(lfirst_r);
      STAT_LATE_LAST:  stat_val = 64'(llast_r);
      default:         stat_val = '0;
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stat_idx_r  <= cmd.stat_idx;
      stat_val_r  <= stat_val;
      stat_last_r <= (cmd.stat_idx == STAT_LATE_LAST);
    end
  end

  assign out_stat_index  = stat_idx_r;
  assign out_stat_value  = stat_val_r;
  assign out_last_of_run = stat_last_r;

endmodule
